@@ sv/jsec_pkg.sv @@
package jsec_pkg;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int MaxBytes   = 6;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CTRL_TOP  = 8'h20;
    localparam logic [7:0] ASCII_TOP = 8'h80;

    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    typedef struct packed {
        logic [1:0]                  pre_bad;
        logic [2:0]                  nbytes;
        logic [MaxBytes-1:0][7:0]    bytes;
        logic [1:0]                  post_bad;
        logic                        str_end;
    } jsec_cmd_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_MAIN,
        PH_POST
    } jsec_phase_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
        begin
            r = 8'h30 + {4'd0, n};
        end
        else
        begin
            r = 8'h57 + {4'd0, n};
        end
        return r;
    endfunction

    function automatic logic [7:0] repl_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_U;
            3'd2:    r = CH_F;
            3'd3:    r = CH_F;
            3'd4:    r = CH_F;
            default: r = CH_D;
        endcase
        return r;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == LEAD_E0)
        begin
            lo = 8'hA0;
        end
        else if (lead == LEAD_ED)
        begin
            hi = 8'h9F;
        end
        else if (lead == LEAD_F0)
        begin
            lo = 8'h90;
        end
        else if (lead == LEAD_F4)
        begin
            hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

@@ sv/json_string_escape_utf8_check.sv @@
// channel   signals                                        direction
// input     in_valid, in_ready, in_byte, string_end        into block
// output    out_valid, out_ready, out_char, run_last,      out of block
//           string_done
//
// one output character per cycle while out_ready is high and a command is queued;
// an input byte causes 0 to 24 characters, sent by the character expander in the back end
// input bytes enter one per cycle while the four-entry command queue has room
// reset clears the pending sequence, the queue and the expander position
// a stalled output holds its character and lets up to three commands queue behind it
module json_string_escape_utf8_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       string_done
);
    import jsec_pkg::*;

    jsec_cmd_t push_cmd;
    jsec_cmd_t head_cmd;
    logic      push_valid;
    logic      push_ready;
    logic      head_valid;
    logic      head_pop;

    jsec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .string_end (string_end),
        .cmd_valid  (push_valid),
        .cmd_ready  (push_ready),
        .cmd        (push_cmd)
    );

    jsec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_cmd   (head_cmd)
    );

    jsec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_pop    (head_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

@@ sv/jsec_front.sv @@
module jsec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 string_end,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output jsec_pkg::jsec_cmd_t  cmd
);
    import jsec_pkg::*;

    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic [1:0]      held_count_reg;
    logic [1:0]      held_count_next;
    logic [2:0]      seq_len_reg;
    logic [2:0]      seq_len_next;
    logic            seq_ok;
    logic            do_fresh;
    logic            has_out;
    logic            take;
    jsec_cmd_t       c;

    assign seq_ok = (held_count_reg == 2'd1) ? second_ok(held_reg[0], in_byte)
                                             : (in_byte[7:6] == 2'b10);

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        c               = '0;
        do_fresh        = 1'b1;
        if (held_count_reg != 2'd0)
        begin
            if (seq_ok)
            begin
                do_fresh = 1'b0;
                if ({1'b0, held_count_reg} + 3'd1 == seq_len_reg)
                begin
                    c.bytes[0] = held_reg[0];
                    c.bytes[1] = held_reg[1];
                    c.bytes[2] = held_reg[2];
                    case (held_count_reg)
                        2'd1:    c.bytes[1] = in_byte;
                        2'd2:    c.bytes[2] = in_byte;
                        default: c.bytes[3] = in_byte;
                    endcase
                    c.nbytes        = {1'b0, held_count_reg} + 3'd1;
                    held_count_next = 2'd0;
                    seq_len_next    = 3'd0;
                end
                else
                begin
                    case (held_count_reg)
                        2'd1:    held_next[1] = in_byte;
                        default: held_next[2] = in_byte;
                    endcase
                    held_count_next = held_count_reg + 2'd1;
                end
            end
            else
            begin
                c.pre_bad       = held_count_reg;
                held_count_next = 2'd0;
                seq_len_next    = 3'd0;
            end
        end
        if (do_fresh)
        begin
            if (in_byte == CH_QUOTE || in_byte == CH_BSLASH)
            begin
                c.nbytes   = 3'd2;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = in_byte;
            end
            else if (in_byte == CH_LF)
            begin
                c.nbytes   = 3'd2;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = CH_N;
            end
            else if (in_byte == CH_CR)
            begin
                c.nbytes   = 3'd2;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = CH_R;
            end
            else if (in_byte == CH_TAB)
            begin
                c.nbytes   = 3'd2;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = CH_T;
            end
            else if (in_byte < CTRL_TOP)
            begin
                c.nbytes   = 3'd6;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = CH_U;
                c.bytes[2] = CH_ZERO;
                c.bytes[3] = CH_ZERO;
                c.bytes[4] = hex_digit(in_byte[7:4]);
                c.bytes[5] = hex_digit(in_byte[3:0]);
            end
            else if (in_byte < ASCII_TOP)
            begin
                c.nbytes   = 3'd1;
                c.bytes[0] = in_byte;
            end
            else if (in_byte inside {[8'hC2:8'hDF]})
            begin
                held_next[0]    = in_byte;
                held_count_next = 2'd1;
                seq_len_next    = 3'd2;
            end
            else if (in_byte inside {[8'hE0:8'hEF]})
            begin
                held_next[0]    = in_byte;
                held_count_next = 2'd1;
                seq_len_next    = 3'd3;
            end
            else if (in_byte inside {[8'hF0:8'hF4]})
            begin
                held_next[0]    = in_byte;
                held_count_next = 2'd1;
                seq_len_next    = 3'd4;
            end
            else
            begin
                c.nbytes   = 3'd6;
                c.bytes[0] = CH_BSLASH;
                c.bytes[1] = CH_U;
                c.bytes[2] = CH_F;
                c.bytes[3] = CH_F;
                c.bytes[4] = CH_F;
                c.bytes[5] = CH_D;
            end
        end
        if (string_end)
        begin
            c.post_bad      = held_count_next;
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end
        c.str_end = string_end;
    end

    assign has_out   = (c.pre_bad != 2'd0) || (c.nbytes != 3'd0) || (c.post_bad != 2'd0);
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid && has_out;
    assign cmd       = c;
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
        end
        else if (take)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    a_len_covers_held: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> seq_len_reg > {1'b0, held_count_reg})
        else $error("pending sequence shorter than held bytes");

    a_empty_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == 2'd0 |-> seq_len_reg == 3'd0)
        else $error("sequence length left without held bytes");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && string_end |=> held_count_reg == 2'd0)
        else $error("hold not cleared at string end");

endmodule

@@ sv/jsec_queue.sv @@
module jsec_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  jsec_pkg::jsec_cmd_t  push_cmd,
    output logic                 head_valid,
    input  logic                 head_pop,
    output jsec_pkg::jsec_cmd_t  head_cmd
);
    import jsec_pkg::*;

    jsec_cmd_t        entries_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW:0]   count_reg;
    logic [QPtrW:0]   count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != QueueDepth[QPtrW:0];
    assign head_valid = count_reg != '0;
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QueueDepth[QPtrW:0])
        else $error("queue overfilled");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[QPtrW-1:0] == wr_ptr_reg - rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

@@ sv/jsec_back.sv @@
module jsec_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  jsec_pkg::jsec_cmd_t  head_cmd,
    output logic                 head_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 run_last,
    output logic                 string_done
);
    import jsec_pkg::*;

    jsec_phase_t phase_reg;
    jsec_phase_t phase_next;
    jsec_phase_t eff;
    logic [2:0]  char_reg;
    logic [2:0]  char_next;
    logic [1:0]  bad_reg;
    logic [1:0]  bad_next;
    logic        tok_end;
    logic        phase_end;
    logic        item_last;
    logic        fire;
    logic [7:0]  ch;

    always_comb
    begin
        eff = phase_reg;
        if (eff == PH_PRE && head_cmd.pre_bad == 2'd0)
        begin
            eff = PH_MAIN;
        end
        if (eff == PH_MAIN && head_cmd.nbytes == 3'd0)
        begin
            eff = PH_POST;
        end
    end

    always_comb
    begin
        tok_end   = (char_reg == 3'd5);
        phase_end = 1'b0;
        item_last = 1'b0;
        ch        = repl_char(char_reg);
        case (eff)
            PH_PRE:
            begin
                phase_end = tok_end && (bad_reg == head_cmd.pre_bad - 2'd1);
                item_last = phase_end && (head_cmd.nbytes == 3'd0)
                            && (head_cmd.post_bad == 2'd0);
            end
            PH_MAIN:
            begin
                tok_end = (char_reg == head_cmd.nbytes - 3'd1);
                case (char_reg)
                    3'd0:    ch = head_cmd.bytes[0];
                    3'd1:    ch = head_cmd.bytes[1];
                    3'd2:    ch = head_cmd.bytes[2];
                    3'd3:    ch = head_cmd.bytes[3];
                    3'd4:    ch = head_cmd.bytes[4];
                    default: ch = head_cmd.bytes[5];
                endcase
                phase_end = tok_end;
                item_last = phase_end && (head_cmd.post_bad == 2'd0);
            end
            default:
            begin
                phase_end = tok_end && (bad_reg == head_cmd.post_bad - 2'd1);
                item_last = phase_end;
            end
        endcase
    end

    assign fire        = head_valid && out_ready;
    assign out_valid   = head_valid;
    assign out_char    = ch;
    assign run_last    = item_last;
    assign string_done = item_last && head_cmd.str_end;
    assign head_pop    = fire && item_last;

    always_comb
    begin
        phase_next = phase_reg;
        char_next  = char_reg;
        bad_next   = bad_reg;
        if (fire)
        begin
            if (item_last)
            begin
                phase_next = PH_PRE;
                char_next  = 3'd0;
                bad_next   = 2'd0;
            end
            else if (phase_end)
            begin
                phase_next = (eff == PH_PRE) ? PH_MAIN : PH_POST;
                char_next  = 3'd0;
                bad_next   = 2'd0;
            end
            else if (tok_end)
            begin
                phase_next = eff;
                char_next  = 3'd0;
                bad_next   = bad_reg + 2'd1;
            end
            else
            begin
                phase_next = eff;
                char_next  = char_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE;
            char_reg  <= 3'd0;
            bad_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            char_reg  <= char_next;
            bad_reg   <= bad_next;
        end
    end

    a_main_index: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && eff == PH_MAIN |-> char_reg < head_cmd.nbytes)
        else $error("character index past end of copied bytes");

    a_mid_item_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PRE || char_reg != 3'd0 || bad_reg != 2'd0) |-> head_valid)
        else $error("expansion in progress without a queued command");

endmodule
